@@ rtl/aetq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aetq_pkg
// Shared types and constants for the box table: opcodes, status codes,
// controller states, the stored box record and the token that walks the cells.
// ----------------------------------------------------------------------------
package aetq_pkg;

  localparam int MaxEntriesDef = 128;
  localparam logic [7:0] WallBit = 8'h01;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_FIND    = 3'd2,
    OP_OVERLAP = 3'd3,
    OP_SETPOS  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADIDX = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_MOVE,
    S_RESP
  } fsm_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
    logic [7:0]         flags;
  } entry_t;

  // mv: second pass of a delete, carrying the last entry to the hole
  typedef struct packed {
    logic   valid;
    logic   mv;
    logic   found;
    entry_t data;
  } tok_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
    logic [7:0]         kind;
    logic [7:0]         mask;
    logic               excl;
    logic               wr_ins;
    logic               wr_pos;
  } ctl_t;

endpackage

@@ rtl/aetq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aetq_cell
// One table slot. Holds a box record, compares it against the broadcast
// request as the token passes, and hands the registered token to the next slot.
// ----------------------------------------------------------------------------
module aetq_cell import aetq_pkg::*; #(
  parameter int CellIdx = 0,
  parameter int IdxW    = 7,
  parameter int XW      = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ctl_t            ctl,
  input  logic [XW-1:0]   cnt,
  input  logic [XW-1:0]   idx,
  input  logic [XW-1:0]   last,
  input  tok_t            tok_in,
  input  logic [IdxW-1:0] rix_in,
  output tok_t            tok_out,
  output logic [IdxW-1:0] rix_out
);

  localparam logic [XW-1:0] MyIdx = XW'(CellIdx);

  entry_t            entry_r, entry_nxt;
  tok_t              tok_r, tok_nxt;
  logic [IdxW-1:0]   rix_r, rix_nxt;

  logic              live;
  logic              is_idx;
  logic              hit_find;
  logic              hit_ovl;
  logic              overlap;
  logic signed [17:0] qx, qy, ex, ey;
  logic signed [17:0] qx_end, qy_end, ex_end, ey_end;

  assign live   = (MyIdx < cnt);
  assign is_idx = (MyIdx == idx);

  assign qx     = {{2{ctl.x[15]}}, ctl.x};
  assign qy     = {{2{ctl.y[15]}}, ctl.y};
  assign ex     = {{2{entry_r.x[15]}}, entry_r.x};
  assign ey     = {{2{entry_r.y[15]}}, entry_r.y};
  assign qx_end = qx + {3'b000, ctl.w};
  assign qy_end = qy + {3'b000, ctl.h};
  assign ex_end = ex + {3'b000, entry_r.w};
  assign ey_end = ey + {3'b000, entry_r.h};

  assign overlap = (qx_end > ex) && (qx < ex_end) && (qy_end > ey) && (qy < ey_end);

  assign hit_find = live && (entry_r.x == ctl.x) && (entry_r.y == ctl.y) &&
                    (entry_r.w == ctl.w) && (entry_r.h == ctl.h);

  assign hit_ovl = live && !(ctl.excl && is_idx) && ((entry_r.flags & ctl.mask) != 8'h00) &&
                   overlap;

  always_comb begin
    tok_nxt = tok_in;
    rix_nxt = rix_in;
    case (ctl.op)
      OP_FIND: begin
        if (tok_in.valid && hit_find) begin
          tok_nxt.found = 1'b1;
          rix_nxt       = IdxW'(CellIdx);
        end
      end
      OP_OVERLAP: begin
        if (tok_in.valid && hit_ovl && !tok_in.found) begin
          tok_nxt.found = 1'b1;
          rix_nxt       = IdxW'(CellIdx);
        end
      end
      OP_DELETE: begin
        if (tok_in.valid && !tok_in.mv && (MyIdx == last)) begin
          tok_nxt.data = entry_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.wr_ins && (MyIdx == cnt)) begin
      entry_nxt.x     = ctl.x;
      entry_nxt.y     = ctl.y;
      entry_nxt.w     = ctl.w;
      entry_nxt.h     = ctl.h;
      entry_nxt.flags = ctl.kind | WallBit;
    end
    if (ctl.wr_pos && is_idx) begin
      entry_nxt.x = ctl.x;
      entry_nxt.y = ctl.y;
    end
    if ((ctl.op == OP_DELETE) && tok_in.valid && tok_in.mv && is_idx) begin
      entry_nxt = tok_in.data;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    rix_r   <= rix_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;
  assign rix_out = rix_r;

endmodule

@@ rtl/aabb_entity_table_query.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_entity_table_query
// Table of axis-aligned boxes with insert, delete, exact find, overlap query
// and reposition, one request at a time over a chain of slot cells.
// ----------------------------------------------------------------------------
// One request is worked at a time; the next request is taken once the result
// is in the output register, even while that result waits to be taken. Each
// slot is a cell and a token walks the chain one cell per cycle. Insert, set
// position, unused opcodes and requests rejected for a full table or a bad
// index go from execution straight to the result; find and overlap query
// send the token down the chain once, and delete twice (one walk to fetch
// the last entry, one to drop it into the hole). A result still held by
// out_stall keeps the next finished request waiting and the input stalled.
// No clearing pass after reset; slots at or above the live count are never
// reported.
module aabb_entity_table_query import aetq_pkg::*; #(
  parameter int MAX_ENTRIES = MaxEntriesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [14:0] in_width,
  input  logic [14:0] in_height,
  input  logic [7:0]  in_kind_flags,
  input  logic [7:0]  in_type_mask,
  input  logic [6:0]  in_entry_index,
  input  logic        in_exclude_enable,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [6:0]  out_result_index,
  output logic [1:0]  out_status,
  output logic [7:0]  out_live_count
);

  localparam int IdxW = $clog2(MAX_ENTRIES);
  localparam int CntW = $clog2(MAX_ENTRIES + 1);
  localparam int XW   = (CntW > 7) ? CntW : 7;

  fsm_t            state_r, state_nxt;
  ctl_t            q_r;
  logic [6:0]      q_idx_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            res_found_r, res_found_nxt;
  logic [IdxW-1:0] res_rix_r, res_rix_nxt;
  status_t         res_status_r, res_status_nxt;

  logic            out_valid_r;
  logic            out_found_r;
  logic [6:0]      out_rix_r;
  logic [1:0]      out_status_r;
  logic [7:0]      out_live_r;

  logic            accept;
  logic            out_load;
  logic            full;
  logic            bad_idx;
  logic [XW-1:0]   cnt_ext, idx_ext, last_ext;
  logic            wr_ins, wr_pos;
  ctl_t            ctl;
  tok_t            launch;

  tok_t            tok_w [0:MAX_ENTRIES];
  logic [IdxW-1:0] rix_w [0:MAX_ENTRIES];

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  assign cnt_ext  = XW'(cnt_r);
  assign idx_ext  = XW'(q_idx_r);
  assign last_ext = cnt_ext - XW'(1);
  assign full     = (cnt_r >= CntW'(MAX_ENTRIES));
  assign bad_idx  = (idx_ext >= cnt_ext);

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r.op     <= in_op;
      q_r.x      <= in_pos_x;
      q_r.y      <= in_pos_y;
      q_r.w      <= in_width;
      q_r.h      <= in_height;
      q_r.kind   <= in_kind_flags;
      q_r.mask   <= in_type_mask;
      q_r.excl   <= in_exclude_enable;
      q_r.wr_ins <= 1'b0;
      q_r.wr_pos <= 1'b0;
      q_idx_r    <= in_entry_index;
    end
  end

  always_comb begin
    ctl        = q_r;
    ctl.wr_ins = wr_ins;
    ctl.wr_pos = wr_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    res_found_nxt  = res_found_r;
    res_rix_nxt    = res_rix_r;
    res_status_nxt = res_status_r;
    wr_ins         = 1'b0;
    wr_pos         = 1'b0;
    out_load       = 1'b0;
    launch.valid   = 1'b0;
    launch.mv      = 1'b0;
    launch.found   = 1'b0;
    launch.data    = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_found_nxt  = 1'b0;
          res_rix_nxt    = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        case (q_r.op)
          OP_INSERT: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              wr_ins      = 1'b1;
              res_rix_nxt = IdxW'(cnt_r);
              cnt_nxt     = cnt_r + CntW'(1);
            end
          end
          OP_DELETE: begin
            if (bad_idx) begin
              res_status_nxt = ST_BADIDX;
            end else begin
              launch.valid = 1'b1;
              state_nxt    = S_SCAN;
            end
          end
          OP_FIND, OP_OVERLAP: begin
            launch.valid = 1'b1;
            state_nxt    = S_SCAN;
          end
          OP_SETPOS: begin
            if (bad_idx) begin
              res_status_nxt = ST_BADIDX;
            end else begin
              wr_pos = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (tok_w[MAX_ENTRIES].valid) begin
          if (q_r.op == OP_DELETE) begin
            launch.valid = 1'b1;
            launch.mv    = 1'b1;
            launch.data  = tok_w[MAX_ENTRIES].data;
            state_nxt    = S_MOVE;
          end else begin
            res_found_nxt = tok_w[MAX_ENTRIES].found;
            res_rix_nxt   = rix_w[MAX_ENTRIES];
            state_nxt     = S_RESP;
          end
        end
      end
      S_MOVE: begin
        if (tok_w[MAX_ENTRIES].valid) begin
          cnt_nxt   = cnt_r - CntW'(1);
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_found_r  <= res_found_nxt;
    res_rix_r    <= res_rix_nxt;
    res_status_r <= res_status_nxt;
  end

  assign tok_w[0] = launch;
  assign rix_w[0] = '0;

  for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
    aetq_cell #(
      .CellIdx (gi),
      .IdxW    (IdxW),
      .XW      (XW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .cnt     (cnt_ext),
      .idx     (idx_ext),
      .last    (last_ext),
      .tok_in  (tok_w[gi]),
      .rix_in  (rix_w[gi]),
      .tok_out (tok_w[gi+1]),
      .rix_out (rix_w[gi+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r  <= res_found_r;
      out_rix_r    <= 7'(res_rix_r);
      out_status_r <= res_status_r;
      out_live_r   <= 8'(cnt_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_result_index = out_rix_r;
  assign out_status       = out_status_r;
  assign out_live_count   = out_live_r;

`ifndef ASSERT_OFF
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MAX_ENTRIES))
    else $error("live count above table size");

  a_tok_end: assert property (@(posedge clk) disable iff (!rst_n)
    tok_w[MAX_ENTRIES].valid |-> (state_r == S_SCAN || state_r == S_MOVE))
    else $error("token left the chain outside a scan");

  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result presented without a finished request");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted request not executed");

  a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |->
      $past(state_r == S_EXEC || state_r == S_MOVE))
    else $error("live count changed outside insert or delete");
`endif

endmodule
